// ===== hdl/ucs_pkg.sv =====
// Shared constants, types and sequencer states of the UCB1 child selector.
package ucs_pkg;

  localparam int CNT_W        = 20;
  localparam int WEIGHT_W     = 16;
  localparam int INDEX_W      = 8;
  localparam int SCORE_W      = 24;
  localparam int FRAC_W       = 20;
  localparam int DVD_W        = CNT_W + FRAC_W;
  localparam int DVS_W        = CNT_W + 1;
  localparam int ROOT_W       = 22;
  localparam int MANT_W       = 31;
  localparam int LOG_W        = 25;
  localparam int MUL_W        = 32;
  localparam int MAX_CHILDREN_DEF = 256;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd23101;
  localparam logic [29:0]         LN2_Q30    = 30'd744261118;
  localparam logic [SCORE_W-1:0]  SCORE_MAX  = {SCORE_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_EXPLOIT,
    ST_NORM,
    ST_SQ,
    ST_SQW,
    ST_LNMUL,
    ST_LNW,
    ST_RATIO,
    ST_ROOT,
    ST_EXMUL,
    ST_EXW,
    ST_SCORE,
    ST_EMIT
  } ucs_state_t;

endpackage

// ===== hdl/ucs_req_if.sv =====
// Request channel: one child of the node per request.
interface ucs_req_if;
  logic                         valid;
  logic                         ready;
  logic                         child_present;
  logic [ucs_pkg::CNT_W-1:0]    child_wins;
  logic [ucs_pkg::CNT_W-1:0]    child_visits;
  logic [ucs_pkg::CNT_W-1:0]    parent_visits;
  logic                         last_child;

  modport source (output valid, child_present, child_wins, child_visits,
                  parent_visits, last_child, input ready);
  modport sink (input valid, child_present, child_wins, child_visits,
                parent_visits, last_child, output ready);
endinterface

// ===== hdl/ucs_rsp_if.sv =====
// Response channel: the selected child of one set.
interface ucs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [ucs_pkg::INDEX_W-1:0]  best_index;
  logic [ucs_pkg::SCORE_W-1:0]  best_score;

  modport source (output valid, found, best_index, best_score, input ready);
  modport sink (input valid, found, best_index, best_score, output ready);
endinterface

// ===== hdl/ucs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ucs_div #(
  parameter int DVD_W = ucs_pkg::DVD_W,
  parameter int DVS_W = ucs_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] q;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DVS_W:0]   trial;

  assign trial    = {rem, q[DVD_W-1]};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
        q    <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= DVS_W'(trial - {1'b0, dvs});
          q   <= {q[DVD_W-2:0], 1'b1};
        end else begin
          rem <= trial[DVS_W-1:0];
          q   <= {q[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/ucs_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module ucs_sqrt #(
  parameter int ROOT_W = ucs_pkg::ROOT_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2*ROOT_W-1:0] radicand,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);
  localparam int CW = $clog2(ROOT_W + 1);
  localparam int RW = ROOT_W + 4;

  logic [2*ROOT_W-1:0] x;
  logic [RW-1:0]       rem;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [RW-1:0]       sh;
  logic [RW-1:0]       trial;

  assign sh    = {rem[RW-3:0], x[2*ROOT_W-1 -: 2]};
  assign trial = RW'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(ROOT_W);
        x    <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        x <= {x[2*ROOT_W-3:0], 2'b00};
        if (sh >= trial) begin
          rem  <= sh - trial;
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= sh;
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hdl/uct_child_selector_top.sv =====
// Top level of the UCB1 child selector: sequencer, shared multiplier, selection.
//
// Children of one node arrive on req, one request each; last_child closes the
// set and one response follows on rsp with the best child (found = 0 for an
// empty set). Scores are unsigned Q4.20, ties go to the later child.
// explore_weight is written through cfg_we / cfg_wdata while idle: the user
// must keep to this, the block itself does not enforce it.
//
// One request at a time: req.ready is high only while idle. A scored child is
// accepted and started, runs the exploit divide, normalizes the parent count,
// does 20 squaring rounds on the shared 32x32 multiplier, the ln2 multiply,
// the ratio divide, the square root, the weight multiply, compare and emit.
// A parent count of zero skips normalization and the squaring rounds. An
// absent or excess child goes straight from accept to emit. The response
// is registered in ST_EMIT, after ST_SCORE compares the last child's score.
//
// Reset clears the running set state and loads the default weight. The
// response is held in an output register; a stalled receiver holds the
// block only when the next set closes before that response is taken.
module uct_child_selector_top #(
  parameter int MAX_CHILDREN = ucs_pkg::MAX_CHILDREN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ucs_pkg::WEIGHT_W-1:0] cfg_wdata,
  ucs_req_if.sink                      req,
  ucs_rsp_if.source                    rsp
);
  import ucs_pkg::*;

  localparam int CW = $clog2(MAX_CHILDREN + 1);

  ucs_state_t state, state_next;

  logic [WEIGHT_W-1:0] ew;
  logic                c_last;
  logic [CNT_W-1:0]    c_wins;
  logic [CNT_W-1:0]    c_visits;
  logic [CW-1:0]       count;
  logic [SCORE_W-1:0]  top_score;
  logic [INDEX_W-1:0]  top_index;
  logic                any_seen;
  logic [CNT_W-1:0]    pn;
  logic [4:0]          k;
  logic [MANT_W-1:0]   m;
  logic [FRAC_W-1:0]   frac;
  logic [4:0]          rnd;
  logic [SCORE_W-1:0]  exploit;
  logic [SCORE_W-1:0]  explore;
  logic [2*MUL_W-1:0]  prod;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;

  logic                div_start;
  logic [DVD_W-1:0]    div_dvd;
  logic                div_done;
  logic [DVD_W-1:0]    div_q;
  logic                sq_start;
  logic                sq_done;
  logic [ROOT_W-1:0]   sq_root;
  logic [SCORE_W:0]    sum;
  logic [SCORE_W-1:0]  score;
  logic [MUL_W-1:0]    sq_val;
  logic                emit_ok;
  logic                emit_fire;

  assign req.ready = (state == ST_IDLE);
  assign sq_val    = prod[2*MUL_W-3:MANT_W-1];
  assign sum       = {1'b0, exploit} + {1'b0, explore};
  assign score     = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
  assign emit_ok   = !rsp.valid || rsp.ready;
  assign emit_fire = (state == ST_EMIT) && c_last && emit_ok;

  ucs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  ({1'b0, c_visits} + DVS_W'(1)),
    .done     (div_done),
    .quotient (div_q)
  );

  ucs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({div_q[SCORE_W-1:0], FRAC_W'(0)}),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_dvd    = {c_wins, FRAC_W'(0)};
    sq_start   = 1'b0;
    mul_a      = MUL_W'(m);
    mul_b      = MUL_W'(m);
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.child_present && count < CW'(MAX_CHILDREN)) begin
            state_next = ST_START;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_EXPLOIT;
      end
      ST_EXPLOIT: begin
        if (div_done) begin
          state_next = (pn == '0) ? ST_LNMUL : ST_NORM;
        end
      end
      ST_NORM: begin
        if (pn[CNT_W-1]) begin
          state_next = ST_SQ;
        end
      end
      ST_SQ: begin
        state_next = ST_SQW;
      end
      ST_SQW: begin
        state_next = (rnd == 5'd1) ? ST_LNMUL : ST_SQ;
      end
      ST_LNMUL: begin
        mul_a      = MUL_W'({k, frac});
        mul_b      = MUL_W'(LN2_Q30);
        state_next = ST_LNW;
      end
      ST_LNW: begin
        div_start  = 1'b1;
        div_dvd    = DVD_W'(prod[SCORE_W+29:30]);
        state_next = ST_RATIO;
      end
      ST_RATIO: begin
        if (div_done) begin
          sq_start   = 1'b1;
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          state_next = ST_EXMUL;
        end
      end
      ST_EXMUL: begin
        mul_a      = MUL_W'(ew);
        mul_b      = MUL_W'(sq_root);
        state_next = ST_EXW;
      end
      ST_EXW: begin
        state_next = ST_SCORE;
      end
      ST_SCORE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!c_last || emit_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      ew        <= WEIGHT_RST;
      count     <= '0;
      top_score <= '0;
      top_index <= '0;
      any_seen  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        ew <= cfg_wdata;
      end
      if (rsp.valid && rsp.ready && !emit_fire) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            c_last   <= req.last_child;
            c_wins   <= req.child_wins;
            c_visits <= req.child_visits;
            pn       <= req.parent_visits;
            k        <= 5'd19;
            frac     <= '0;
            rnd      <= 5'd20;
          end
        end
        ST_EXPLOIT: begin
          if (div_done) begin
            exploit <= (|div_q[DVD_W-1:SCORE_W]) ? SCORE_MAX : div_q[SCORE_W-1:0];
            k       <= (pn == '0) ? 5'd0 : k;
          end
        end
        ST_NORM: begin
          if (pn[CNT_W-1]) begin
            m <= {pn, 11'b0};
          end else begin
            pn <= {pn[CNT_W-2:0], 1'b0};
            k  <= k - 5'd1;
          end
        end
        ST_SQW: begin
          rnd <= rnd - 5'd1;
          if (sq_val[MUL_W-1]) begin
            m    <= sq_val[MUL_W-1:1];
            frac <= {frac[FRAC_W-2:0], 1'b1};
          end else begin
            m    <= sq_val[MANT_W-1:0];
            frac <= {frac[FRAC_W-2:0], 1'b0};
          end
        end
        ST_EXW: begin
          explore <= prod[SCORE_W+13:14];
        end
        ST_SCORE: begin
          if (!any_seen || score >= top_score) begin
            top_score <= score;
            top_index <= INDEX_W'(count);
            any_seen  <= 1'b1;
          end
          count <= count + 1'b1;
        end
        ST_EMIT: begin
          if (c_last && emit_ok) begin
            rsp.valid      <= 1'b1;
            rsp.found      <= any_seen;
            rsp.best_index <= any_seen ? top_index : '0;
            rsp.best_score <= any_seen ? top_score : '0;
            count          <= '0;
            top_score      <= '0;
            top_index      <= '0;
            any_seen       <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== verif/ucs_score_checker.sv =====
// Checker for the UCB1 child selector: predicts each set's selection and compares responses.
`timescale 1ns / 1ps
module ucs_score_checker
  import ucs_pkg::*;
#(
  parameter int MAX_CHILDREN = MAX_CHILDREN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [WEIGHT_W-1:0] cfg_wdata,
  ucs_req_if                  req,
  ucs_rsp_if                  rsp,
  output int                  errors,
  output int                  pending,
  output int                  selections
);

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
    logic [SCORE_W-1:0] score;
  } pick_t;

  pick_t              picks_q[$];
  logic [WEIGHT_W-1:0] weight;
  logic [SCORE_W-1:0]  top_score;
  logic [INDEX_W-1:0]  top_index;
  int unsigned         child_cnt;
  logic                any_seen;

  function automatic logic [63:0] log2_fix(input logic [CNT_W-1:0] p);
    int unsigned k;
    logic [63:0] m;
    logic [63:0] frac;
    k = 0;
    frac = 0;
    if (p == 0) return 0;
    while (k < 31 && (p >> (k + 1)) != 0) k++;
    m = 64'(p) << (30 - k);
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(k) << 20) | frac;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [SCORE_W-1:0] ucb1(input logic [CNT_W-1:0] wins,
                                               input logic [CNT_W-1:0] visits,
                                               input logic [CNT_W-1:0] parent,
                                               input logic [WEIGHT_W-1:0] c);
    logic [63:0] d, exploit, ln, ratio, root, explore, s;
    d = 64'(visits) + 1;
    exploit = (64'(wins) << 20) / d;
    ln = (log2_fix(parent) * 64'(LN2_Q30)) >> 30;
    ratio = ln / d;
    root = int_sqrt(ratio << 20);
    explore = (64'(c) * root) >> 14;
    if (exploit > 64'(SCORE_MAX)) exploit = 64'(SCORE_MAX);
    s = exploit + explore;
    if (s > 64'(SCORE_MAX)) s = 64'(SCORE_MAX);
    return s[SCORE_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic [SCORE_W-1:0] s;
    pick_t got, want;
    if (rst) begin
      weight = WEIGHT_RST;
      top_score = 0;
      top_index = 0;
      child_cnt = 0;
      any_seen = 0;
      picks_q.delete();
      errors = 0;
      selections = 0;
    end else begin
      if (cfg_we) weight = cfg_wdata;
      if (req.valid && req.ready) begin
        if (req.child_present && child_cnt < MAX_CHILDREN) begin
          s = ucb1(req.child_wins, req.child_visits, req.parent_visits, weight);
          if (!any_seen || s >= top_score) begin
            top_score = s;
            top_index = child_cnt[INDEX_W-1:0];
            any_seen = 1;
          end
          child_cnt++;
        end
        if (req.last_child) begin
          picks_q.insert(picks_q.size(),
                         any_seen ? pick_t'{1'b1, top_index, top_score} : pick_t'{0, 0, 0});
          top_score = 0;
          top_index = 0;
          child_cnt = 0;
          any_seen = 0;
        end
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.found, rsp.best_index, rsp.best_score};
        selections++;
        if (picks_q.size() == 0) begin
          if (errors < 10) $display("unexpected response found=%0d index=%0d score=%0h",
                                    got.found, got.index, got.score);
          errors++;
        end else begin
          want = picks_q.pop_front();
          if (got != want) begin
            if (errors < 10)
              $display("mismatch: expected found=%0d index=%0d score=%0h, got %0d %0d %0h",
                       want.found, want.index, want.score, got.found, got.index, got.score);
            errors++;
          end
        end
      end
    end
    pending = picks_q.size();
  end

endmodule

// ===== verif/uct_child_selector_top_tb.sv =====
// Testbench top for the UCB1 child selector: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module uct_child_selector_top_tb;
  import ucs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic                clk = 0;
  logic                rst = 1;
  logic                cfg_we = 0;
  logic [WEIGHT_W-1:0] cfg_wdata = 0;
  int                  errors, pending, selections;
  int                  cycles = 0;
  int                  children = 0;
  bit                  steady = 0;
  int                  rsp_hold = 0;

  ucs_req_if req ();
  ucs_rsp_if rsp ();

  uct_child_selector_top i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  ucs_score_checker i_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp),
    .errors(errors), .pending(pending), .selections(selections)
  );

  always #4 clk = ~clk;

  initial begin
    req.valid = 0;
    req.child_present = 0;
    req.child_wins = 0;
    req.child_visits = 0;
    req.parent_visits = 0;
    req.last_child = 0;
    rsp.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // response side back-pressure: short stalls, occasional long ones, quiet stretches
  always @(posedge clk) begin
    if (rsp_hold > 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp.ready <= 0;
    end else if (!steady && $urandom_range(0, 9) < 3) begin
      rsp_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(20, 300);
      rsp.ready <= 0;
    end else begin
      rsp.ready <= 1;
    end
  end

  function automatic int pick_gap();
    if (steady) return 0;
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 60);
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CNT_MAX;
      2: return CNT_W'($urandom_range(0, 15));
      3: return CNT_W'($urandom_range(0, 1000));
      default: return CNT_W'($urandom_range(0, CNT_MAX));
    endcase
  endfunction

  task automatic send_child(input logic present, input logic [CNT_W-1:0] wins,
                            input logic [CNT_W-1:0] visits, input logic [CNT_W-1:0] parent,
                            input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.child_present <= present;
    req.child_wins <= wins;
    req.child_visits <= visits;
    req.parent_visits <= parent;
    req.last_child <= last;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    children++;
  endtask

  task automatic settle_and_write(input logic [WEIGHT_W-1:0] w);
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_sets(input int n_items);
    int sent, size;
    logic [CNT_W-1:0] parent;
    sent = 0;
    while (sent < n_items) begin
      steady = ($urandom_range(0, 9) < 2);
      parent = ($urandom_range(0, 3) == 0) ? pick_count() : CNT_W'($urandom_range(1, CNT_MAX));
      size = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < size; i++) begin
        if ($urandom_range(0, 19) == 0) parent = pick_count();
        send_child($urandom_range(0, 9) != 0, pick_count(), pick_count(), parent,
                   i == size - 1);
        sent++;
      end
      if (size == 0) begin
        send_child(0, pick_count(), pick_count(), parent, 1);
        sent++;
      end
    end
    steady = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, empty set, ignored item, ties, parent of zero and one
    send_child(1, CNT_MAX, 0, CNT_MAX, 1);
    send_child(1, 0, CNT_MAX, CNT_MAX, 1);
    send_child(1, 0, 0, 1, 1);
    send_child(1, 5, 3, 0, 1);
    send_child(0, 7, 7, 100, 1);
    send_child(0, 1, 1, 50, 0);
    send_child(1, 3, 9, 50, 0);
    send_child(1, 3, 9, 50, 0);
    send_child(1, 3, 9, 50, 1);
    send_child(1, 0, 0, CNT_MAX, 0);
    send_child(1, CNT_MAX, CNT_MAX, CNT_MAX, 0);
    send_child(0, 0, 0, CNT_MAX, 0);
    send_child(1, 12, 40, CNT_MAX, 1);
    send_child(1, 10, 20, 2, 0);
    send_child(1, 1, 0, 2, 1);

    settle_and_write(0);
    send_child(1, 3, 9, 1000, 0);
    send_child(1, 1, 999, 1000, 1);
    random_sets(80);

    settle_and_write('1);
    send_child(1, 0, 0, CNT_MAX, 1);
    random_sets(80);

    // oversized set: children past the limit are dropped
    settle_and_write(WEIGHT_W'($urandom_range(0, 65535)));
    steady = 1;
    for (int i = 0; i < 262; i++)
      send_child(1, (i % 7 == 0) ? 20'd900 : CNT_W'($urandom_range(0, 100)), 20'd100,
                 20'd5000, i == 261);
    steady = 0;
    random_sets(60);

    settle_and_write(1);
    random_sets(70);
    settle_and_write(WEIGHT_RST);
    random_sets(80);

    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d child requests, checked %0d selections under five weights,",
             children, selections);
    $display("including empty, tied, saturating and oversized child sets.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ucs_pkg.sv
hdl/ucs_req_if.sv
hdl/ucs_rsp_if.sv
hdl/ucs_div.sv
hdl/ucs_sqrt.sv
hdl/uct_child_selector_top.sv
verif/ucs_score_checker.sv
verif/uct_child_selector_top_tb.sv
